### src/mqttrd_pkg.sv
// Shared types and constants of the MQTT receive deframer.
`default_nettype none

package mqttrd_pkg;

  // Packet types, taken from the high nibble of the fixed-header byte.
  localparam logic [3:0] KIND_CONNACK = 4'h2;
  localparam logic [3:0] KIND_PUBLISH = 4'h3;
  localparam logic [3:0] KIND_PUBACK  = 4'h4;
  localparam logic [3:0] KIND_SUBACK  = 4'h9;

  localparam int unsigned LEFT_W = 28;

  typedef enum logic [1:0] {
    FRAME_HEADER = 2'd0,
    FRAME_LENGTH = 2'd1,
    FRAME_BODY   = 2'd2
  } frame_phase_t;

  // Position inside the body. The meaning of each step depends on the type:
  // for PUBLISH the steps are topic length high and low, topic bytes,
  // packet id high and low, and payload.
  typedef enum logic [2:0] {
    BODY_S0 = 3'd0,
    BODY_S1 = 3'd1,
    BODY_S2 = 3'd2,
    BODY_S3 = 3'd3,
    BODY_S4 = 3'd4,
    BODY_S5 = 3'd5
  } body_phase_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_CONNACK = 3'd1,
    EV_PUBACK  = 3'd2,
    EV_SUBACK  = 3'd3,
    EV_TOPIC   = 3'd4,
    EV_PAYLOAD = 3'd5
  } event_t;

  typedef struct packed {
    event_t      event_res;
    logic [7:0]  data_byte;
    logic        part_last;
    logic [7:0]  return_code;
    logic [15:0] packet_id;
    logic [1:0]  qos_level;
    logic        session_ok;
    logic        send_puback;
  } result_t;

endpackage

`default_nettype wire

### src/mqtt_receive_deframer.sv
// Top level of the MQTT receive deframer: input handshake and result register.
//
// The block takes received MQTT bytes on the input channel (in_valid,
// in_stall, rx_byte) and gives exactly one result item per byte on the
// output channel (out_valid, out_stall and the result fields). A byte is
// taken at a rising edge where in_valid is high and in_stall is low; a
// result is taken where out_valid is high and out_stall is low.
//
// Each byte is decoded in the cycle it is accepted, against the parser
// state, and its result is loaded into the result register at the same
// edge. One byte can be accepted in every cycle in which in_stall is
// low. The result register is the only buffer: while a result waits
// and the receiver stalls, in_stall is raised, and a new byte is taken
// in the same cycle that the waiting result is taken.
//
// Synchronous reset clears the parser to "awaiting a fixed-header byte",
// clears the session flag and empties the result register.
// MAX_LENGTH_BYTES sets how many remaining-length bytes are read (1 to 4).
`default_nettype none

module mqtt_receive_deframer
  import mqttrd_pkg::*;
#(
  parameter int unsigned MAX_LENGTH_BYTES = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       event_res,
  output logic [7:0]       data_byte,
  output logic             part_last,
  output logic [7:0]       return_code,
  output logic [15:0]      packet_id,
  output logic [1:0]       qos_level,
  output logic             session_ok,
  output logic             send_puback
);

  logic    accept;
  result_t step_res;
  result_t res_q;

  // Stall the sender only while a result is held and the receiver stalls.
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  mqttrd_core #(
    .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (accept),
    .rx_byte(rx_byte),
    .res    (step_res)
  );

  // Result register: the valid flag is control, the payload needs no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_q <= step_res;
    end
  end

  assign event_res   = res_q.event_res;
  assign data_byte   = res_q.data_byte;
  assign part_last   = res_q.part_last;
  assign return_code = res_q.return_code;
  assign packet_id   = res_q.packet_id;
  assign qos_level   = res_q.qos_level;
  assign session_ok  = res_q.session_ok;
  assign send_puback = res_q.send_puback;

endmodule

`default_nettype wire

### src/mqttrd_core.sv
// Parser state and per-byte decode of the MQTT receive deframer.
`default_nettype none

module mqttrd_core
  import mqttrd_pkg::*;
#(
  parameter int unsigned MAX_LENGTH_BYTES = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] rx_byte,
  output result_t         res
);

  frame_phase_t        frame_phase, frame_phase_next;
  body_phase_t         body_phase, body_phase_next;
  logic [7:0]          header_byte, header_byte_next;
  logic [LEFT_W-1:0]   bytes_left, bytes_left_next;
  logic [1:0]          length_shift, length_shift_next;
  logic [15:0]         topic_length, topic_length_next;
  logic [15:0]         topic_count, topic_count_next;
  logic [15:0]         id_reg, id_reg_next;
  logic [1:0]          qos_reg, qos_reg_next;
  logic                accepted_flag, accepted_flag_next;

  logic [LEFT_W-1:0]   len_part;
  logic [LEFT_W-1:0]   left_or;
  logic [LEFT_W-1:0]   left_dec;
  logic [2:0]          shift_plus;
  logic [15:0]         count_inc;
  logic                body_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_phase   <= FRAME_HEADER;
      body_phase    <= BODY_S0;
      header_byte   <= '0;
      bytes_left    <= '0;
      length_shift  <= '0;
      topic_length  <= '0;
      topic_count   <= '0;
      id_reg        <= '0;
      qos_reg       <= '0;
      accepted_flag <= 1'b0;
    end else if (step) begin
      frame_phase   <= frame_phase_next;
      body_phase    <= body_phase_next;
      header_byte   <= header_byte_next;
      bytes_left    <= bytes_left_next;
      length_shift  <= length_shift_next;
      topic_length  <= topic_length_next;
      topic_count   <= topic_count_next;
      id_reg        <= id_reg_next;
      qos_reg       <= qos_reg_next;
      accepted_flag <= accepted_flag_next;
    end
  end

  // Length byte placed at its 7-bit group.
  always_comb begin
    case (length_shift)
      2'd0:    len_part = {21'd0, rx_byte[6:0]};
      2'd1:    len_part = {14'd0, rx_byte[6:0], 7'd0};
      2'd2:    len_part = {7'd0, rx_byte[6:0], 14'd0};
      default: len_part = {rx_byte[6:0], 21'd0};
    endcase
  end

  assign left_or    = bytes_left | len_part;
  assign left_dec   = bytes_left - LEFT_W'(1);
  assign shift_plus = {1'b0, length_shift} + 3'd1;
  assign count_inc  = topic_count + 16'd1;
  assign body_end   = (bytes_left == LEFT_W'(1));

  always_comb begin
    frame_phase_next   = frame_phase;
    body_phase_next    = body_phase;
    header_byte_next   = header_byte;
    bytes_left_next    = bytes_left;
    length_shift_next  = length_shift;
    topic_length_next  = topic_length;
    topic_count_next   = topic_count;
    id_reg_next        = id_reg;
    qos_reg_next       = qos_reg;
    accepted_flag_next = accepted_flag;

    res             = '0;
    res.event_res   = EV_NONE;

    case (frame_phase)
      FRAME_HEADER: begin
        header_byte_next  = rx_byte;
        bytes_left_next   = '0;
        length_shift_next = '0;
        body_phase_next   = BODY_S0;
        id_reg_next       = '0;
        qos_reg_next      = (rx_byte[7:4] == KIND_PUBLISH) ? rx_byte[2:1] : 2'd0;
        frame_phase_next  = FRAME_LENGTH;
      end
      FRAME_LENGTH: begin
        bytes_left_next = left_or;
        if (rx_byte[7] && (shift_plus < 3'(MAX_LENGTH_BYTES))) begin
          length_shift_next = shift_plus[1:0];
        end else begin
          frame_phase_next = (left_or == '0) ? FRAME_HEADER : FRAME_BODY;
        end
      end
      FRAME_BODY: begin
        case (header_byte[7:4])
          KIND_CONNACK: begin
            if (body_phase == BODY_S0) begin
              body_phase_next = BODY_S1;
            end else if (body_phase == BODY_S1) begin
              accepted_flag_next = (rx_byte == 8'd0);
              res.event_res      = EV_CONNACK;
              res.return_code    = rx_byte;
              body_phase_next    = BODY_S2;
            end
          end
          KIND_PUBACK: begin
            if (body_phase == BODY_S0) begin
              id_reg_next     = {rx_byte, 8'd0};
              body_phase_next = BODY_S1;
            end else if (body_phase == BODY_S1) begin
              id_reg_next     = {id_reg[15:8], rx_byte};
              res.event_res   = EV_PUBACK;
              res.packet_id   = {id_reg[15:8], rx_byte};
              body_phase_next = BODY_S2;
            end
          end
          KIND_SUBACK: begin
            if (body_phase == BODY_S0) begin
              id_reg_next     = {rx_byte, 8'd0};
              body_phase_next = BODY_S1;
            end else if (body_phase == BODY_S1) begin
              id_reg_next     = {id_reg[15:8], rx_byte};
              body_phase_next = BODY_S2;
            end else if (body_phase == BODY_S2) begin
              res.event_res   = EV_SUBACK;
              res.return_code = rx_byte;
              res.packet_id   = id_reg;
              body_phase_next = BODY_S3;
            end
          end
          KIND_PUBLISH: begin
            case (body_phase)
              BODY_S0: begin
                topic_length_next = {rx_byte, 8'd0};
                body_phase_next   = BODY_S1;
              end
              BODY_S1: begin
                topic_length_next = {topic_length[15:8], rx_byte};
                topic_count_next  = '0;
                if ({topic_length[15:8], rx_byte} != 16'd0) begin
                  body_phase_next = BODY_S2;
                end else begin
                  body_phase_next = (qos_reg != 2'd0) ? BODY_S3 : BODY_S5;
                end
              end
              BODY_S2: begin
                topic_count_next = count_inc;
                res.event_res    = EV_TOPIC;
                res.data_byte    = rx_byte;
                res.qos_level    = qos_reg;
                if (count_inc == topic_length) begin
                  res.part_last   = 1'b1;
                  body_phase_next = (qos_reg != 2'd0) ? BODY_S3 : BODY_S5;
                end
              end
              BODY_S3: begin
                id_reg_next     = {rx_byte, 8'd0};
                body_phase_next = BODY_S4;
              end
              BODY_S4: begin
                id_reg_next     = {id_reg[15:8], rx_byte};
                body_phase_next = BODY_S5;
                // A message with an empty payload ends on the id low byte.
                if (body_end && (qos_reg == 2'd1)) begin
                  res.send_puback = 1'b1;
                  res.packet_id   = {id_reg[15:8], rx_byte};
                  res.qos_level   = qos_reg;
                end
              end
              BODY_S5: begin
                res.event_res = EV_PAYLOAD;
                res.data_byte = rx_byte;
                res.qos_level = qos_reg;
                res.packet_id = id_reg;
                if (body_end) begin
                  res.part_last   = 1'b1;
                  res.send_puback = (qos_reg == 2'd1);
                end
              end
              default: begin
              end
            endcase
          end
          default: begin
          end
        endcase
        bytes_left_next = left_dec;
        if (left_dec == '0) begin
          frame_phase_next = FRAME_HEADER;
        end
      end
      default: begin
        frame_phase_next = FRAME_HEADER;
      end
    endcase

    res.session_ok = accepted_flag_next;
  end

endmodule

`default_nettype wire
